FILE: rtl/gosf_pkg.sv
// Shared types and constants of the glyph outline smoothing filter.
`default_nettype none

package gosf_pkg;

    // Pixel and register widths
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 4;

    // Rows are counted up to the largest legal frame height
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // Reset frame size
    localparam int RESET_WIDTH  = 64;
    localparam int RESET_HEIGHT = 32;

    // Results that one pixel releases: none, one, or two on the last row
    typedef struct packed {
        logic [1:0]       count;
        logic [PIX_W-1:0] pix0;
        logic             last0;
        logic [PIX_W-1:0] pix1;
        logic             last1;
    } res_pair_t;

endpackage

`default_nettype wire

FILE: rtl/gosf_out_queue.sv
// Two-entry result queue that parts the filter pipeline from the result channel.
`default_nettype none

module gosf_out_queue (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire gosf_pkg::res_pair_t           pair,
    output logic                               room,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [gosf_pkg::PIX_W-1:0]         m_pixel_out,
    output logic                               m_frame_last
);

    logic [1:0]                   cnt_reg;
    logic [1:0]                   cnt_next;
    logic [gosf_pkg::PIX_W-1:0]   q0_pix_reg, q0_pix_next;
    logic [gosf_pkg::PIX_W-1:0]   q1_pix_reg, q1_pix_next;
    logic                         q0_last_reg, q0_last_next;
    logic                         q1_last_reg, q1_last_next;
    logic                         pop;
    logic [1:0]                   left_cnt;
    logic [gosf_pkg::PIX_W-1:0]   a_pix;
    logic                         a_last;

    assign m_valid      = (cnt_reg != 2'd0);
    assign m_pixel_out  = q0_pix_reg;
    assign m_frame_last = q0_last_reg;
    assign pop          = m_valid && m_ready;

    // Entries left after this cycle's pop, and the new head
    always_comb begin
        left_cnt = cnt_reg - {1'b0, pop};
        a_pix    = pop ? q1_pix_reg : q0_pix_reg;
        a_last   = pop ? q1_last_reg : q0_last_reg;
        room     = ({1'b0, left_cnt} + {1'b0, pair.count}) <= 3'd2;
    end

    // Append the pushed results behind what stays
    always_comb begin
        q0_pix_next  = a_pix;
        q0_last_next = a_last;
        q1_pix_next  = q1_pix_reg;
        q1_last_next = q1_last_reg;
        cnt_next     = left_cnt;
        if (push) begin
            cnt_next = left_cnt + pair.count;
            case (left_cnt)
                2'd0: begin
                    q0_pix_next  = pair.pix0;
                    q0_last_next = pair.last0;
                    q1_pix_next  = pair.pix1;
                    q1_last_next = pair.last1;
                end
                2'd1: begin
                    q1_pix_next  = pair.pix0;
                    q1_last_next = pair.last0;
                end
                default: begin
                    q1_pix_next  = q1_pix_reg;
                    q1_last_next = q1_last_reg;
                end
            endcase
        end
    end

    // Occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        q0_pix_reg  <= q0_pix_next;
        q0_last_reg <= q0_last_next;
        q1_pix_reg  <= q1_pix_next;
        q1_last_reg <= q1_last_next;
    end

    // Never more than two entries
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("result queue overfilled");

    // The pipeline only pushes when the results fit
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> room)
        else $error("push without room");

    // A pair of results only arrives into an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && pair.count == 2'd2) |-> (left_cnt == 2'd0))
        else $error("pair pushed behind pending results");

endmodule

`default_nettype wire

FILE: rtl/glyph_outline_smoothing_filter.sv
// Five-point cross smoothing of a padded glyph frame, streamed in raster order.
// A pixel's result is sent on m_ via the compute stage and the result queue after the
// pixel one row below is accepted. Throughput: one pixel per cycle while the queue has
// room; on the last row two results per pixel, so the single-beat port slows that row's input.
// Reset (synchronous): counters clear, frame size returns to 64 x 32; line stores keep
// their contents; words read before being written within a frame never reach a result.
`default_nettype none

module glyph_outline_smoothing_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [gosf_pkg::PIX_W-1:0]        s_pixel_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [gosf_pkg::PIX_W-1:0]             m_pixel_out,
    output logic                                   m_frame_last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gosf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gosf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = gosf_pkg::ROW_W;
    localparam int PW        = gosf_pkg::PIX_W;
    localparam int RESET_W   = (MAX_WIDTH < gosf_pkg::RESET_WIDTH) ?
                               MAX_WIDTH : gosf_pkg::RESET_WIDTH;

    // Frame geometry, held as last column and last row
    logic [CW-1:0]  last_col_reg;
    logic [RW-1:0]  last_row_reg;
    logic [gosf_pkg::FW_W-1:0] cfg_fw;
    logic [gosf_pkg::FH_W-1:0] cfg_fh;
    logic [CW-1:0]  cfg_last_col;
    logic [RW-1:0]  cfg_last_row;
    logic           cfg_wr;

    // Raster position of the next input beat
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           s_acc;
    logic           at_last_col;

    // Line stores
    logic [PW-1:0]  raw_mem    [MAX_WIDTH];
    logic [PW-1:0]  smooth_mem [MAX_WIDTH];
    logic [PW-1:0]  rd_raw_reg;
    logic [PW-1:0]  rd_smooth_reg;
    logic [CW-1:0]  raw_rd_addr;

    // Compute stage
    logic           s1_valid_reg;
    logic [PW-1:0]  s1_px_reg;
    logic [CW-1:0]  s1_col_reg;
    logic           s1_border_reg;
    logic           s1_col_last_reg;
    logic           s1_has_res_reg;
    logic           s1_two_reg;
    logic           s1_adv;
    logic [PW-1:0]  centre_reg;
    logic [PW-1:0]  left_reg;
    logic [10:0]    sum;
    logic [PW-1:0]  res;

    gosf_pkg::res_pair_t pair;
    logic           room;

    // Configuration: always ready, clamp to the legal range
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_fw    = cfg_data[gosf_pkg::FW_W-1:0];
    assign cfg_fh    = cfg_data[gosf_pkg::FH_W-1:0];

    always_comb begin
        if (cfg_fw < gosf_pkg::FW_W'(3)) begin
            cfg_last_col = CW'(2);
        end else if (32'(cfg_fw) > 32'(MAX_WIDTH)) begin
            cfg_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            cfg_last_col = CW'(cfg_fw - gosf_pkg::FW_W'(1));
        end
        if (cfg_fh < gosf_pkg::FH_W'(3)) begin
            cfg_last_row = RW'(2);
        end else if (32'(cfg_fh) > 32'(gosf_pkg::MAX_HEIGHT)) begin
            cfg_last_row = RW'(gosf_pkg::MAX_HEIGHT - 1);
        end else begin
            cfg_last_row = RW'(cfg_fh - gosf_pkg::FH_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= CW'(RESET_W - 1);
            last_row_reg <= RW'(gosf_pkg::RESET_HEIGHT - 1);
        end else if (cfg_wr) begin
            case (cfg_index)
                gosf_pkg::REG_FRAME_WIDTH:  last_col_reg <= cfg_last_col;
                gosf_pkg::REG_FRAME_HEIGHT: last_row_reg <= cfg_last_row;
                default: begin
                    last_col_reg <= last_col_reg;
                end
            endcase
        end
    end

    // Input handshake: take a beat when the compute stage is free or moving on
    assign s_ready     = !s1_valid_reg || s1_adv;
    assign s_acc       = s_valid && s_ready;
    assign at_last_col = (col_reg == last_col_reg);

    // Advance the raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_acc) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Prefetch the right neighbour; at row end fetch column zero for the next row
    assign raw_rd_addr = at_last_col ? '0 : col_reg + CW'(1);

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            raw_mem[col_reg] <= s_pixel_in;
            rd_raw_reg       <= raw_mem[raw_rd_addr];
        end
    end

    // Smoothed row: read above at accept, write back from the compute stage
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_smooth_reg <= smooth_mem[col_reg];
        end
        if (s1_adv && s1_has_res_reg) begin
            smooth_mem[s1_col_reg] <= res;
        end
    end

    // Compute stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Compute stage payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_px_reg       <= s_pixel_in;
            s1_col_reg      <= col_reg;
            s1_border_reg   <= (row_reg == RW'(1)) || (col_reg == '0) || at_last_col;
            s1_col_last_reg <= at_last_col;
            s1_has_res_reg  <= (row_reg != '0);
            s1_two_reg      <= (row_reg == last_row_reg);
        end
    end

    // Shift the centre and left neighbours as each pixel leaves the stage
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            left_reg <= '0;
        end else if (s1_adv) begin
            left_reg <= s1_col_last_reg ? '0 : centre_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            centre_reg <= rd_raw_reg;
        end
    end

    // Weighted cross sum, divided by eight
    assign sum = {1'b0, centre_reg, 2'b00} + 11'(left_reg) + 11'(rd_smooth_reg)
               + 11'(rd_raw_reg) + 11'(s1_px_reg);
    assign res = s1_border_reg ? centre_reg : sum[10:3];

    // Results released by this pixel
    always_comb begin
        pair.count = s1_has_res_reg ? (s1_two_reg ? 2'd2 : 2'd1) : 2'd0;
        pair.pix0  = res;
        pair.last0 = 1'b0;
        pair.pix1  = s1_px_reg;
        pair.last1 = s1_col_last_reg;
    end

    assign s1_adv = s1_valid_reg && room;

    gosf_out_queue u_out_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (s1_adv),
        .pair         (pair),
        .room         (room),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_frame_last (m_frame_last)
    );

    // An accepted beat always occupies the compute stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> s1_valid_reg)
        else $error("accepted beat lost before compute stage");

    // A beat on the last column wraps the column counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && at_last_col && !cfg_wr) |=> (col_reg == '0))
        else $error("column counter failed to wrap");

    // Two results only come from a row that has a result at all
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_two_reg) |-> s1_has_res_reg)
        else $error("last-row pixel without smoothed result");

    // The column counter stays inside the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !cfg_wr) |-> (col_reg <= last_col_reg))
        else $error("column counter beyond frame width");

endmodule

`default_nettype wire
